/* src/flma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flash LED mode arbiter package
// Shared types, codes and arithmetic constants for the arbiter blocks.
// ----------------------------------------------------------------------------
package flma_pkg;

  localparam int MA_W      = 11;  // milliamp register width
  localparam int CODE_W    = 12;  // drive code width
  localparam int LEVEL_W   = 3;   // request level index width
  localparam int CFG_IDX_W = 2;   // configuration register index width
  localparam int BASE_W    = 8;   // 2*mA/25 fits in eight bits
  localparam int NUM_W     = 18;  // scaled numerator before the final divide
  localparam int PROD1_W   = 23;  // (2*mA) times reciprocal of 25
  localparam int PROD3_W   = 39;  // numerator times reciprocal of 79 or 15

  // Division by 25 as a multiply by ceil(2^15/25) and a shift; exact for 2*mA < 4096.
  localparam int RECIP_25  = 1311;
  localparam int SHIFT_25  = 15;

  // Flash level: (base*1000 + 78) / 79, torch and preflash: (base*200 + 14) / 15.
  localparam int FLASH_SCALE = 1000;
  localparam int FLASH_ROUND = 'h4E;
  localparam int TORCH_SCALE = 200;
  localparam int TORCH_ROUND = 'h0E;

  // Both final divides share one shift of 24: ceil(2^24/79) and ceil(2^19/15) << 5.
  localparam int RECIP_79    = 212370;
  localparam int RECIP_15_SH = 34953 * 32;
  localparam int DIV_SHIFT   = 24;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_TORCH    = 2'd1,
    MODE_PREFLASH = 2'd2,
    MODE_FLASH    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_MOVE  = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TORCH    = 2'd0,
    CFG_PREFLASH = 2'd1,
    CFG_FLASH    = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_t;

  // Requester codes.
  localparam logic REQ_CAMERA = 1'b0;
  localparam logic REQ_OTHER  = 1'b1;

  // Precomputed settings for one level.
  typedef struct packed {
    logic              off_req;  // milliamps are zero: the level means off
    logic [CODE_W-1:0] code;     // drive code for the level
  } lvl_cfg_t;

  typedef struct packed {
    lvl_cfg_t torch;
    lvl_cfg_t preflash;
    lvl_cfg_t flash;
  } cfg_set_t;

  // Everything reported for one request.
  typedef struct packed {
    mode_t             led_mode;
    logic [CODE_W-1:0] torch_drive;
    logic [CODE_W-1:0] flash_drive;
    logic              flash_supply_on;
    logic              torch_supply_on;
    logic              camera_owns;
    logic              other_owns;
    status_t           status;
  } res_t;

endpackage
`default_nettype wire

/* src/flma_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the requesting user and the level index.
// ----------------------------------------------------------------------------
interface flma_in_if
  import flma_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LEVEL_W-1:0] level_index;

  modport source (output valid, output req_type, output level_index, input ready);
  modport sink   (input valid, input req_type, input level_index, output ready);
endinterface
`default_nettype wire

/* src/flma_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the arbiter state after each request.
// ----------------------------------------------------------------------------
interface flma_out_if
  import flma_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        led_mode;
  logic [CODE_W-1:0] torch_drive;
  logic [CODE_W-1:0] flash_drive;
  logic              flash_supply_on;
  logic              torch_supply_on;
  logic              camera_owns;
  logic              other_owns;
  logic [1:0]        status;

  modport source (output valid, output led_mode, output torch_drive, output flash_drive,
                  output flash_supply_on, output torch_supply_on, output camera_owns,
                  output other_owns, output status, input ready);
  modport sink   (input valid, input led_mode, input torch_drive, input flash_drive,
                  input flash_supply_on, input torch_supply_on, input camera_owns,
                  input other_owns, input status, output ready);
endinterface
`default_nettype wire

/* src/flma_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and the value to write.
// ----------------------------------------------------------------------------
interface flma_cfg_if
  import flma_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/flash_led_mode_arbiter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flash LED mode arbiter
// Shares one camera flash LED between the camera user and a second torch
// user, tracking mode, ownership, drive codes and supply enables.
// ----------------------------------------------------------------------------
// The arbiter takes one request per clock when not held back as set out
// below, and returns one result per request, in order. A request is
// captured in an input register, resolved by a single pass of transition
// logic against the stored state and the result is held in an output
// register; a stalled result stops new requests only once the input
// register holds one as well. Milliamp settings are converted into drive
// codes when they are written, by a three-stage multiply pipeline, so the
// request channel is held not ready while a write to one of the three
// settings is in the pipeline registers and the new code settles; a
// request is also not taken in a cycle in which a setting is being
// written. At all other times the sustained rate is one request per
// cycle, as long as the result side keeps taking results. Writes to a
// register index beyond the three settings are taken and ignored.
// ----------------------------------------------------------------------------
module flash_led_mode_arbiter_top
  import flma_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  flma_in_if.sink    in_ch,
  flma_out_if.source out_ch,
  flma_cfg_if.sink   cfg_ch
);

  logic               cvt_busy;
  cfg_set_t           cfg_set;
  res_t               res;
  res_t               out_res_r;
  logic               out_v_r;
  logic               s1_v_r;
  logic               s1_req_r;
  logic [LEVEL_W-1:0] s1_lvl_r;
  logic               adv;
  logic               fire;
  logic               in_acc;

  // Settings are accepted in every cycle; each write to one of the three settings goes down the converter.
  assign cfg_ch.ready = 1'b1;

  flma_cvt u_cvt (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .busy    (cvt_busy),
    .cfg_set (cfg_set)
  );

  // The output register moves on when it is empty or its result is taken.
  // The held request is resolved and committed to the state on that move.
  // A request arriving alongside a settings write waits until the new code
  // has settled, so it always sees a consistent off flag and drive code.
  assign adv          = !out_v_r || out_ch.ready;
  assign fire         = s1_v_r && adv;
  assign in_ch.ready  = (!s1_v_r || adv) && !cvt_busy && !cfg_ch.valid;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_ch.req_type;
      s1_lvl_r <= in_ch.level_index;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  flma_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (fire),
    .req_type    (s1_req_r),
    .level_index (s1_lvl_r),
    .cfg_set     (cfg_set),
    .res         (res)
  );

  assign out_ch.valid           = out_v_r;
  assign out_ch.led_mode        = out_res_r.led_mode;
  assign out_ch.torch_drive     = out_res_r.torch_drive;
  assign out_ch.flash_drive     = out_res_r.flash_drive;
  assign out_ch.flash_supply_on = out_res_r.flash_supply_on;
  assign out_ch.torch_supply_on = out_res_r.torch_supply_on;
  assign out_ch.camera_owns     = out_res_r.camera_owns;
  assign out_ch.other_owns      = out_res_r.other_owns;
  assign out_ch.status          = out_res_r.status;

endmodule
`default_nettype wire

/* src/flma_cvt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Milliamp to drive code converter
// Three-stage pipeline that turns each milliamp setting written for one of
// the three levels into its drive code and keeps the results.
// ----------------------------------------------------------------------------
module flma_cvt
  import flma_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_idx,
  input  wire logic [MA_W-1:0]      wr_data,
  output      logic                 busy,
  output      cfg_set_t             cfg_set
);

  logic                 s1_v_r, s2_v_r;
  logic [CFG_IDX_W-1:0] s1_idx_r, s2_idx_r;
  logic [BASE_W-1:0]    s1_base_r, base_nxt;
  logic [NUM_W-1:0]     s2_num_r, num_nxt;
  logic [PROD1_W-1:0]   prod1;
  logic [BASE_W-1:0]    quot1;
  logic [PROD3_W-1:0]   prod3;
  logic [PROD3_W-DIV_SHIFT-1:0] quot3;
  logic [CODE_W-1:0]    code;
  logic                 wr_known;
  cfg_set_t             cfg_set_r;

  assign wr_known = (wr_idx == CFG_TORCH) || (wr_idx == CFG_PREFLASH) || (wr_idx == CFG_FLASH);

  // Stage one: base = 2*mA/25, less one when above one, else zero.
  always_comb begin
    prod1    = PROD1_W'({wr_data, 1'b0}) * PROD1_W'(RECIP_25);
    quot1    = prod1[SHIFT_25 +: BASE_W];
    base_nxt = (quot1 > BASE_W'(1)) ? quot1 - BASE_W'(1) : '0;
  end

  // Stage two: scale and add the rounding term for the level's formula.
  always_comb begin
    if (s1_idx_r == CFG_FLASH) begin
      num_nxt = NUM_W'(s1_base_r) * NUM_W'(FLASH_SCALE) + NUM_W'(FLASH_ROUND);
    end else begin
      num_nxt = NUM_W'(s1_base_r) * NUM_W'(TORCH_SCALE) + NUM_W'(TORCH_ROUND);
    end
  end

  // Stage three: reciprocal divide, then a floor of one.
  always_comb begin
    if (s2_idx_r == CFG_FLASH) begin
      prod3 = PROD3_W'(s2_num_r) * PROD3_W'(RECIP_79);
    end else begin
      prod3 = PROD3_W'(s2_num_r) * PROD3_W'(RECIP_15_SH);
    end
    quot3 = prod3[PROD3_W-1:DIV_SHIFT];
    code  = (quot3 == '0) ? CODE_W'(1) : quot3[CODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= wr_en && wr_known;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= wr_idx;
    s1_base_r <= base_nxt;
    s2_idx_r  <= s1_idx_r;
    s2_num_r  <= num_nxt;
  end

  // The off flag follows the write at once; the code lands after the stage-one and stage-two registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_set_r.torch    <= '{off_req: 1'b1, code: '0};
      cfg_set_r.preflash <= '{off_req: 1'b1, code: '0};
      cfg_set_r.flash    <= '{off_req: 1'b1, code: '0};
    end else begin
      if (wr_en) begin
        unique case (cfg_idx_t'(wr_idx))
          CFG_TORCH:    cfg_set_r.torch.off_req    <= (wr_data == '0);
          CFG_PREFLASH: cfg_set_r.preflash.off_req <= (wr_data == '0);
          CFG_FLASH:    cfg_set_r.flash.off_req    <= (wr_data == '0);
          default: ;
        endcase
      end
      if (s2_v_r) begin
        unique case (cfg_idx_t'(s2_idx_r))
          CFG_TORCH:    cfg_set_r.torch.code    <= code;
          CFG_PREFLASH: cfg_set_r.preflash.code <= code;
          CFG_FLASH:    cfg_set_r.flash.code    <= code;
          default: ;
        endcase
      end
    end
  end

  assign busy    = s1_v_r || s2_v_r;
  assign cfg_set = cfg_set_r;

endmodule
`default_nettype wire

/* src/flma_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Arbiter state and transition logic
// Holds mode, ownership, drive codes and supply enables, and works out the
// next values for one request.
// ----------------------------------------------------------------------------
module flma_core
  import flma_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               commit,
  input  wire logic               req_type,
  input  wire logic [LEVEL_W-1:0] level_index,
  input  wire cfg_set_t           cfg_set,
  output      res_t               res
);

  mode_t             mode_r, mode_nxt;
  logic              cam_r, cam_nxt;
  logic              oth_r, oth_nxt;
  logic [CODE_W-1:0] tcode_r, tcode_nxt;
  logic [CODE_W-1:0] fcode_r, fcode_nxt;
  logic              fsup_r, fsup_nxt;
  logic              tsup_r, tsup_nxt;
  status_t           status;
  mode_t             lvl;
  lvl_cfg_t          sel;
  logic              off_req;
  logic              do_on;
  logic              ok_off;

  assign lvl = mode_t'(level_index[1:0]);

  always_comb begin
    unique case (lvl)
      MODE_TORCH:    sel = cfg_set.torch;
      MODE_PREFLASH: sel = cfg_set.preflash;
      MODE_FLASH:    sel = cfg_set.flash;
      default:       sel = '{off_req: 1'b1, code: '0};
    endcase
    off_req = sel.off_req;
    ok_off  = (req_type == REQ_OTHER) ? (!cam_r && oth_r) : (cam_r != oth_r);
  end

  always_comb begin
    mode_nxt  = mode_r;
    cam_nxt   = cam_r;
    oth_nxt   = oth_r;
    tcode_nxt = tcode_r;
    fcode_nxt = fcode_r;
    fsup_nxt  = fsup_r;
    tsup_nxt  = tsup_r;
    status    = ST_DONE;
    do_on     = 1'b0;

    priority if (level_index[LEVEL_W-1]) begin
      status = ST_BAD_INDEX;
    end else if (off_req) begin
      if (ok_off) begin
        unique case (mode_r)
          MODE_PREFLASH: begin
            tcode_nxt = '0;
            mode_nxt  = MODE_OFF;
          end
          MODE_TORCH: begin
            tcode_nxt = '0;
            mode_nxt  = MODE_OFF;
            tsup_nxt  = 1'b0;
          end
          MODE_FLASH: begin
            fcode_nxt = '0;
            mode_nxt  = MODE_OFF;
            fsup_nxt  = 1'b0;
          end
          default: ;
        endcase
        if (req_type == REQ_OTHER) begin
          oth_nxt = 1'b0;
        end else begin
          cam_nxt = 1'b0;
        end
      end else begin
        status = ST_IGNORED;
      end
    end else if (req_type == REQ_OTHER) begin
      if (!cam_r && !oth_r) begin
        do_on   = 1'b1;
        oth_nxt = 1'b1;
      end else begin
        status = ST_IGNORED;
      end
    end else begin
      do_on = 1'b1;
      if (!cam_r) begin
        oth_nxt = 1'b0;
        cam_nxt = 1'b1;
      end
    end

    if (do_on) begin
      unique case (lvl)
        MODE_FLASH: begin
          if (mode_r == MODE_OFF || mode_r == MODE_PREFLASH) begin
            if (mode_r == MODE_PREFLASH) begin
              tcode_nxt = '0;
            end
            fcode_nxt = sel.code;
            mode_nxt  = MODE_FLASH;
          end else begin
            status = ST_BAD_MOVE;
          end
        end
        MODE_PREFLASH: begin
          if (mode_r == MODE_OFF || mode_r == MODE_TORCH) begin
            mode_nxt  = MODE_PREFLASH;
            fsup_nxt  = 1'b1;
            tcode_nxt = sel.code;
          end else if (mode_r != MODE_PREFLASH) begin
            status = ST_BAD_MOVE;
          end
        end
        MODE_TORCH: begin
          if (mode_r == MODE_OFF) begin
            mode_nxt  = MODE_TORCH;
            tsup_nxt  = 1'b1;
            tcode_nxt = sel.code;
          end else if (mode_r != MODE_TORCH) begin
            status = ST_BAD_MOVE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      cam_r   <= 1'b0;
      oth_r   <= 1'b0;
      tcode_r <= '0;
      fcode_r <= '0;
      fsup_r  <= 1'b0;
      tsup_r  <= 1'b0;
    end else if (commit) begin
      mode_r  <= mode_nxt;
      cam_r   <= cam_nxt;
      oth_r   <= oth_nxt;
      tcode_r <= tcode_nxt;
      fcode_r <= fcode_nxt;
      fsup_r  <= fsup_nxt;
      tsup_r  <= tsup_nxt;
    end
  end

  always_comb begin
    res.led_mode        = mode_nxt;
    res.torch_drive     = tcode_nxt;
    res.flash_drive     = fcode_nxt;
    res.flash_supply_on = fsup_nxt;
    res.torch_supply_on = tsup_nxt;
    res.camera_owns     = cam_nxt;
    res.other_owns      = oth_nxt;
    res.status          = status;
  end

  // Only one user can hold the LED at a time.
  a_single_owner: assert property (@(posedge clk) disable iff (!rst_n)
    !(cam_r && oth_r))
    else $error("both users hold the LED");

  // The torch channel is dark whenever the mode is off or full flash.
  a_torch_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_OFF || mode_r == MODE_FLASH) |-> (tcode_r == '0))
    else $error("torch code left set outside torch and preflash");

  // The flash channel carries a code exactly while the mode is full flash.
  a_flash_code: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_FLASH) == (fcode_r != '0))
    else $error("flash code out of step with flash mode");

  // A request that is ignored or has an undefined level leaves the whole state untouched.
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (status == ST_IGNORED || status == ST_BAD_INDEX) |=>
      $stable(mode_r) && $stable(cam_r) && $stable(oth_r) && $stable(tcode_r) &&
      $stable(fcode_r) && $stable(fsup_r) && $stable(tsup_r))
    else $error("refused request changed the state");

endmodule
`default_nettype wire

/* tb/led_arbiter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash LED arbiter result checker
// Keeps its own copy of the arbiter state and settings, works out the state
// after every accepted request and compares each returned result with it.
// ----------------------------------------------------------------------------
module led_arbiter_checker
  import flma_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  flma_in_if          req_mon,
  flma_out_if         res_mon,
  flma_cfg_if         cfg_mon,
  output int unsigned failures,
  output int unsigned outstanding
);

  localparam int unsigned MA_DIVISOR    = 25;
  localparam int unsigned FLASH_DIVISOR = 79;
  localparam int unsigned TORCH_DIVISOR = 15;

  logic [MA_W-1:0]   torch_ma;
  logic [MA_W-1:0]   preflash_ma;
  logic [MA_W-1:0]   flash_ma;

  mode_t             mode_q;
  logic              camera_q;
  logic              other_q;
  logic [CODE_W-1:0] torch_code_q;
  logic [CODE_W-1:0] flash_code_q;
  logic              flash_supply_q;
  logic              torch_supply_q;

  res_t              pending_states[$];
  res_t              oldest;
  int unsigned       error_count = 0;

  function automatic logic [CODE_W-1:0] milliamps_to_code(input logic [MA_W-1:0] ma,
                                                          input logic is_flash);
    int unsigned base;
    int unsigned code;
    base = (2 * int'(ma)) / MA_DIVISOR;
    base = (base > 1) ? base - 1 : 0;
    if (is_flash) begin
      code = (base * FLASH_SCALE + FLASH_ROUND) / FLASH_DIVISOR;
    end else begin
      code = (base * TORCH_SCALE + TORCH_ROUND) / TORCH_DIVISOR;
    end
    if (code < 1) begin
      code = 1;
    end
    return code[CODE_W-1:0];
  endfunction

  // Moves towards a lit level; returns whether the move was allowed.
  function automatic status_t enter_level(input mode_t target, input logic [CODE_W-1:0] code);
    status_t st;
    st = ST_BAD_MOVE;
    case (target)
      MODE_FLASH: begin
        if (mode_q == MODE_OFF || mode_q == MODE_PREFLASH) begin
          if (mode_q == MODE_PREFLASH) begin
            torch_code_q = '0;
          end
          flash_code_q = code;
          mode_q       = MODE_FLASH;
          st           = ST_DONE;
        end
      end
      MODE_PREFLASH: begin
        if (mode_q == MODE_PREFLASH) begin
          st = ST_DONE;
        end else if (mode_q == MODE_OFF || mode_q == MODE_TORCH) begin
          mode_q         = MODE_PREFLASH;
          flash_supply_q = 1'b1;
          torch_code_q   = code;
          st             = ST_DONE;
        end
      end
      default: begin
        if (mode_q == MODE_TORCH) begin
          st = ST_DONE;
        end else if (mode_q == MODE_OFF) begin
          mode_q         = MODE_TORCH;
          torch_supply_q = 1'b1;
          torch_code_q   = code;
          st             = ST_DONE;
        end
      end
    endcase
    return st;
  endfunction

  function automatic res_t resolve_request(input logic who, input logic [LEVEL_W-1:0] lvl);
    status_t         st;
    mode_t           target;
    logic [MA_W-1:0] ma;
    logic            permitted;
    res_t            r;
    st     = ST_DONE;
    target = mode_t'(lvl[1:0]);
    if (lvl > LEVEL_W'(MODE_FLASH)) begin
      st = ST_BAD_INDEX;
    end else begin
      case (target)
        MODE_TORCH:    ma = torch_ma;
        MODE_PREFLASH: ma = preflash_ma;
        MODE_FLASH:    ma = flash_ma;
        default:       ma = '0;
      endcase
      if (ma == '0) begin
        permitted = (who == REQ_OTHER) ? (!camera_q && other_q) : (camera_q != other_q);
        if (permitted) begin
          // Leaving preflash keeps the flash supply up.
          case (mode_q)
            MODE_PREFLASH: torch_code_q = '0;
            MODE_TORCH: begin
              torch_code_q   = '0;
              torch_supply_q = 1'b0;
            end
            MODE_FLASH: begin
              flash_code_q   = '0;
              flash_supply_q = 1'b0;
            end
            default: ;
          endcase
          mode_q = MODE_OFF;
          if (who == REQ_OTHER) begin
            other_q = 1'b0;
          end else begin
            camera_q = 1'b0;
          end
        end else begin
          st = ST_IGNORED;
        end
      end else if (who == REQ_OTHER) begin
        if (!camera_q && !other_q) begin
          st      = enter_level(target, milliamps_to_code(ma, target == MODE_FLASH));
          other_q = 1'b1;
        end else begin
          st = ST_IGNORED;
        end
      end else begin
        st = enter_level(target, milliamps_to_code(ma, target == MODE_FLASH));
        if (!camera_q) begin
          other_q  = 1'b0;
          camera_q = 1'b1;
        end
      end
    end
    r.led_mode        = mode_q;
    r.torch_drive     = torch_code_q;
    r.flash_drive     = flash_code_q;
    r.flash_supply_on = flash_supply_q;
    r.torch_supply_on = torch_supply_q;
    r.camera_owns     = camera_q;
    r.other_owns      = other_q;
    r.status          = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      torch_ma       = '0;
      preflash_ma    = '0;
      flash_ma       = '0;
      mode_q         = MODE_OFF;
      camera_q       = 1'b0;
      other_q        = 1'b0;
      torch_code_q   = '0;
      flash_code_q   = '0;
      flash_supply_q = 1'b0;
      torch_supply_q = 1'b0;
      pending_states.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_t'(cfg_mon.index))
          CFG_TORCH:    torch_ma    = cfg_mon.data;
          CFG_PREFLASH: preflash_ma = cfg_mon.data;
          CFG_FLASH:    flash_ma    = cfg_mon.data;
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        if (pending_states.size() == 0) begin
          error_count++;
          $error("result returned with no request outstanding");
        end else begin
          oldest = pending_states.pop_front();
          check_field("led_mode", oldest.led_mode, res_mon.led_mode);
          check_field("torch_drive", oldest.torch_drive, res_mon.torch_drive);
          check_field("flash_drive", oldest.flash_drive, res_mon.flash_drive);
          check_field("flash_supply_on", oldest.flash_supply_on, res_mon.flash_supply_on);
          check_field("torch_supply_on", oldest.torch_supply_on, res_mon.torch_supply_on);
          check_field("camera_owns", oldest.camera_owns, res_mon.camera_owns);
          check_field("other_owns", oldest.other_owns, res_mon.other_owns);
          check_field("status", oldest.status, res_mon.status);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        pending_states.push_back(resolve_request(req_mon.req_type, req_mon.level_index));
      end
    end
    failures    <= error_count;
    outstanding <= pending_states.size();
  end

endmodule

/* tb/tb_flash_led_mode_arbiter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash LED mode arbiter regression
// Drives requests and milliamp settings into the arbiter, stalls the result
// side at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_flash_led_mode_arbiter_top;
  import flma_pkg::*;

  localparam int HALF_PERIOD_NS  = 6;
  localparam int RESET_CYCLES    = 9;
  // Longest quiet spell of a correct run is the deliberate PRESSURE_HOLD hold on
  // the result side; every other quiet spell is shorter.
  localparam int STALL_LIMIT     = 2000;
  // The arbiter answers through its input and output registers, so a few cycles of quiet
  // are enough before a settings change and before the verdict.
  localparam int SETTLE_CYCLES   = 3;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int PRESSURE_AT     = 500;
  localparam int PRESSURE_HOLD   = 200;

  localparam logic [MA_W-1:0] MA_MAX = '1;
  localparam logic [MA_W-1:0] MA_MIN = 1;

  localparam logic [LEVEL_W-1:0] LVL_OFF      = LEVEL_W'(MODE_OFF);
  localparam logic [LEVEL_W-1:0] LVL_TORCH    = LEVEL_W'(MODE_TORCH);
  localparam logic [LEVEL_W-1:0] LVL_PREFLASH = LEVEL_W'(MODE_PREFLASH);
  localparam logic [LEVEL_W-1:0] LVL_FLASH    = LEVEL_W'(MODE_FLASH);
  localparam logic [LEVEL_W-1:0] LVL_UNDEF_LO = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_UNDEF_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned failures;
  int unsigned outstanding;

  // The sender alternates between calm stretches with no gaps and busy
  // stretches with mostly short and occasionally long gaps.
  bit          sender_calm = 1'b0;
  int unsigned calm_left   = 0;

  flma_in_if  req_if ();
  flma_out_if res_if ();
  flma_cfg_if cfg_if ();

  always #(HALF_PERIOD_NS) clk = ~clk;

  flash_led_mode_arbiter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if),
    .cfg_ch (cfg_if)
  );

  led_arbiter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_if),
    .res_mon     (res_if),
    .cfg_mon     (cfg_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // Offers one request and returns at the edge where it is accepted. Valid
  // is left high so that a back-to-back request follows without a bubble;
  // it is only lowered when a gap is inserted or by the caller.
  task automatic offer_request(input logic who, input logic [LEVEL_W-1:0] lvl);
    int unsigned gap;
    int unsigned r;
    if (calm_left == 0) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      calm_left   = $urandom_range(16, 80);
    end else begin
      calm_left--;
    end
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= who;
    req_if.level_index <= lvl;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [MA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Settings are only changed once the arbiter has answered every request.
  // The unused index is written too; the arbiter must take it and ignore it.
  task automatic reprogram(input logic [MA_W-1:0] torch_ma, input logic [MA_W-1:0] preflash_ma,
                           input logic [MA_W-1:0] flash_ma);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_TORCH, torch_ma);
    write_reg(CFG_NONE, MA_W'($urandom));
    write_reg(CFG_PREFLASH, preflash_ma);
    write_reg(CFG_FLASH, flash_ma);
    cfg_if.valid <= 1'b0;
  endtask

  // Milliamp settings weighted towards the edges of the conversion: zero
  // (the level turns into an off request), values whose code rounds down to
  // the minimum, the first value giving a larger code, and the top of range.
  function automatic logic [MA_W-1:0] pick_milliamps();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return '0;
    end
    if (r < 25) begin
      return MA_MIN;
    end
    if (r < 35) begin
      case ($urandom_range(0, 2))
        0:       return MA_W'(12);
        1:       return MA_W'(13);
        default: return MA_W'(25);
      endcase
    end
    if (r < 45) begin
      return $urandom_range(0, 1) ? MA_MAX : MA_W'(2000);
    end
    return MA_W'($urandom_range(0, MA_MAX));
  endfunction

  // Result side. Mostly ready, with random stalls, some calm stretches with
  // none at all, and once a long hold-off so that the arbiter fills up and
  // pushes back on the request side while requests keep coming.
  initial begin : result_sink
    int unsigned taken;
    int unsigned stall_left;
    int unsigned sink_calm_left;
    bit          sink_calm;
    bit          pressure_done;
    taken          = 0;
    stall_left     = 0;
    sink_calm_left = 0;
    sink_calm      = 1'b0;
    pressure_done  = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        taken++;
      end
      if (sink_calm_left == 0) begin
        sink_calm      = ($urandom_range(0, 3) == 0);
        sink_calm_left = $urandom_range(20, 120);
      end else begin
        sink_calm_left--;
      end
      if (!pressure_done && taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_HOLD;
      end else if (stall_left == 0 && !sink_calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
      res_if.ready <= (stall_left == 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  // Watchdog: a run that stops moving on every channel for too long has hung.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("flash_led_mode_arbiter_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic                who;
    logic [LEVEL_W-1:0]  lvl;
    int unsigned         r;
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_CAMERA;
    req_if.level_index <= LVL_OFF;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_TORCH;
    cfg_if.data        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // With every setting at zero each defined level is an off request, and with
    // nobody holding the LED both users are turned away.
    offer_request(REQ_CAMERA, LVL_TORCH);
    offer_request(REQ_OTHER, LVL_OFF);
    offer_request(REQ_CAMERA, 3'd5);

    // Largest torch current, smallest preflash current, top of the flash range.
    reprogram(MA_MAX, MA_MIN, MA_W'(2000));

    // Camera steps from off through torch, preflash and flash back to off, with a few refused transitions.
    offer_request(REQ_CAMERA, LVL_TORCH);
    offer_request(REQ_CAMERA, LVL_TORCH);
    offer_request(REQ_OTHER, LVL_TORCH);
    offer_request(REQ_CAMERA, LVL_PREFLASH);
    offer_request(REQ_CAMERA, LVL_TORCH);
    offer_request(REQ_CAMERA, LVL_FLASH);
    offer_request(REQ_CAMERA, LVL_PREFLASH);
    offer_request(REQ_CAMERA, LVL_UNDEF_HI);
    offer_request(REQ_CAMERA, LVL_OFF);
    offer_request(REQ_CAMERA, LVL_OFF);
    // The other user takes the free LED, then the camera takes it over.
    offer_request(REQ_OTHER, LVL_PREFLASH);
    offer_request(REQ_CAMERA, LVL_FLASH);
    offer_request(REQ_CAMERA, LVL_OFF);
    // The camera may switch off a torch that the other user holds; the other
    // user then still has to release its claim.
    offer_request(REQ_OTHER, LVL_TORCH);
    offer_request(REQ_CAMERA, LVL_OFF);
    offer_request(REQ_OTHER, LVL_OFF);
    offer_request(REQ_OTHER, LVL_UNDEF_LO);
    // Switching off from preflash leaves the flash supply enabled.
    offer_request(REQ_CAMERA, LVL_PREFLASH);
    offer_request(REQ_CAMERA, LVL_OFF);

    // Random phases, each under its own settings; the first two use the
    // extremes of the milliamp range for every level.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        reprogram(MA_MAX, MA_MAX, MA_MAX);
      end else if (phase == 1) begin
        reprogram(MA_MIN, MA_MIN, MA_MIN);
      end else begin
        reprogram(pick_milliamps(), pick_milliamps(), pick_milliamps());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r   = $urandom_range(0, 99);
        who = ($urandom_range(0, 99) < 40) ? REQ_OTHER : REQ_CAMERA;
        if (r < 25) begin
          lvl = LVL_OFF;
        end else if (r < 87) begin
          lvl = LEVEL_W'($urandom_range(LVL_TORCH, LVL_FLASH));
        end else begin
          lvl = LEVEL_W'($urandom_range(LVL_UNDEF_LO, LVL_UNDEF_HI));
        end
        offer_request(who, lvl);
      end
    end

    // Let every answer come back, then give the arbiter a few more cycles in
    // which a stray result would still be caught.
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("flash_led_mode_arbiter_top regression: pass");
    end else begin
      $display("flash_led_mode_arbiter_top regression: fail");
    end
    $finish;
  end

endmodule
